/* hw/rtl/xkb_pkg.sv */
// shared types, constants and helper functions for the xor key base64 codec
// no dependencies; imported by every module of the block
package xkb_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int KEY_POS_W     = 3;
    localparam int KEY_LEN_W     = 4;
    localparam int KEY_W         = 64;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int RES_MAX       = 4;
    localparam int RES_CNT_W     = 3;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_DIGIT = 8'h30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_BYTES   = 2'd0,
        REG_KEY_LENGTH  = 2'd1,
        REG_DECODE_MODE = 2'd2
    } cfg_reg_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } res_t;

    typedef struct packed {
        logic                 valid;
        logic [RES_CNT_W-1:0] count;
        res_t [RES_MAX-1:0]   items;
    } ld_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = CHAR_UPPER + {2'b00, v};
        else if (v < 6'd52)
            c = CHAR_LOWER + {2'b00, v} - 8'd26;
        else if (v < 6'd62)
            c = CHAR_DIGIT + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            c = CHAR_PLUS;
        else
            c = CHAR_SLASH;
        return c;
    endfunction

    // returns {valid, six-bit value}
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b1, 6'(c - CHAR_UPPER)};
            [8'h61:8'h7A]: r = {1'b1, 6'(c - CHAR_LOWER + 8'd26)};
            [8'h30:8'h39]: r = {1'b1, 6'(c - CHAR_DIGIT + 8'd52)};
            CHAR_PLUS:     r = {1'b1, 6'd62};
            CHAR_SLASH:    r = {1'b1, 6'd63};
            default:       r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [KEY_LEN_W-1:0] key_len_eff(input logic [KEY_LEN_W-1:0] l);
        logic [KEY_LEN_W-1:0] e;
        if (l == '0)
            e = KEY_LEN_W'(1);
        else if (l > KEY_LEN_W'(MAX_KEY_BYTES))
            e = KEY_LEN_W'(MAX_KEY_BYTES);
        else
            e = l;
        return e;
    endfunction

    function automatic logic [KEY_POS_W-1:0] key_start(input logic [KEY_POS_W-1:0] p,
                                                       input logic [KEY_LEN_W-1:0] l);
        return ({1'b0, p} >= l) ? '0 : p;
    endfunction

    function automatic logic [KEY_POS_W-1:0] key_adv(input logic [KEY_POS_W-1:0] p,
                                                     input logic [KEY_LEN_W-1:0] l);
        return (({1'b0, p} + KEY_LEN_W'(1)) >= l) ? '0 : p + KEY_POS_W'(1);
    endfunction

endpackage

/* hw/rtl/xor_key_base64_codec_top.sv */
// Repeating-key XOR with Base64 encode/decode, one byte or character per input item.
// An input item is taken into an input register and processed combinationally; its
// 0 to 4 results go to a result buffer that sends one result per cycle while the
// receiver is ready. The input side accepts an item every cycle while each item makes
// at most one result and the receiver is ready; an item that makes more results holds
// the input, as the next item loads only when the last of them leaves. Encoding works
// on three-byte groups, decoding on four-character groups. A decode_mode write clears
// the codec state; the user makes writes only while the block is idle (not enforced).
// depends on xkb_pkg, xkb_engine, xkb_obuf
module xor_key_base64_codec_top
    import xkb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // data_byte
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // out_byte
    output logic                   m_tlast,
    output logic [0:0]             m_tuser,   // bad_char
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [KEY_W-1:0]     key_bytes_reg;
    logic [KEY_LEN_W-1:0] key_length_reg;
    logic                 decode_mode_reg;
    logic                 clear;
    logic                 ld_rdy;
    ld_t                  ld;

    assign clear = cfg_we && (cfg_index == REG_DECODE_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg   <= '0;
            key_length_reg  <= KEY_LEN_W'(1);
            decode_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_BYTES:   key_bytes_reg   <= cfg_data[KEY_W-1:0];
                REG_KEY_LENGTH:  key_length_reg  <= cfg_data[KEY_LEN_W-1:0];
                REG_DECODE_MODE: decode_mode_reg <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    xkb_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .key_bytes   (key_bytes_reg),
        .key_length  (key_length_reg),
        .decode_mode (decode_mode_reg),
        .clear       (clear),
        .ld_rdy      (ld_rdy),
        .ld          (ld)
    );

    xkb_obuf u_obuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .ld_rdy   (ld_rdy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/xkb_engine.sv */
// input register, codec state and the single-pass encode/decode step
// depends on xkb_pkg; hands each item's results to xkb_obuf as one load
module xkb_engine
    import xkb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    input  logic [KEY_W-1:0]     key_bytes,
    input  logic [KEY_LEN_W-1:0] key_length,
    input  logic                 decode_mode,
    input  logic                 clear,
    input  logic                 ld_rdy,
    output ld_t                  ld
);

    logic                 in_vld_reg;
    logic [7:0]           in_data_reg;
    logic                 in_last_reg;

    logic [KEY_POS_W-1:0] pos_reg, pos_next;
    logic [23:0]          gb_reg, gb_next;
    logic [1:0]           gc_reg, gc_next;
    logic                 pad_reg, pad_next;

    logic                 fire;
    logic [KEY_LEN_W-1:0] len;
    logic [KEY_POS_W-1:0] p0, p1, p2, p3;
    logic [7:0]           k0, k1, k2;

    logic [1:0]           gc_e;
    logic [7:0]           x;
    logic [23:0]          egb;
    logic [2:0]           egc;
    logic [23:0]          g;

    logic [6:0]           dv;
    logic [23:0]          dgb;
    logic                 fen;
    logic [23:0]          fgb;
    logic [2:0]           fgc;
    logic [1:0]           base;

    res_t [RES_MAX-1:0]   items;
    logic [RES_CNT_W-1:0] n;

    assign fire     = in_vld_reg && ld_rdy;
    assign s_tready = !in_vld_reg || ld_rdy;

    assign len = key_len_eff(key_length);
    assign p0  = key_start(pos_reg, len);
    assign p1  = key_adv(p0, len);
    assign p2  = key_adv(p1, len);
    assign p3  = key_adv(p2, len);
    assign k0  = key_bytes[{p0, 3'b000} +: 8];
    assign k1  = key_bytes[{p1, 3'b000} +: 8];
    assign k2  = key_bytes[{p2, 3'b000} +: 8];

    always_comb
    begin
        items    = '0;
        n        = '0;
        pos_next = pos_reg;
        gb_next  = gb_reg;
        gc_next  = gc_reg;
        pad_next = pad_reg;
        fen      = 1'b0;
        fgb      = gb_reg;
        fgc      = {1'b0, gc_reg};
        base     = 2'd0;

        gc_e = (gc_reg > 2'd2) ? 2'd0 : gc_reg;
        x    = in_data_reg ^ k0;
        egb  = {gb_reg[15:0], x};
        egc  = {1'b0, gc_e} + 3'd1;
        g    = (egc == 3'd1) ? {x, 16'h0000} : {egb[15:0], 8'h00};
        dv   = b64_value(in_data_reg);
        dgb  = {gb_reg[17:0], dv[5:0]};

        if (!decode_mode)
        begin
            pos_next = p1;
            if (egc == 3'd3)
            begin
                items[0].data = b64_char(egb[23:18]);
                items[1].data = b64_char(egb[17:12]);
                items[2].data = b64_char(egb[11:6]);
                items[3].data = b64_char(egb[5:0]);
                n       = 3'd4;
                gb_next = '0;
                gc_next = '0;
            end
            else if (in_last_reg)
            begin
                items[0].data = b64_char(g[23:18]);
                items[1].data = b64_char(g[17:12]);
                items[2].data = (egc == 3'd2) ? b64_char(g[11:6]) : CHAR_PAD;
                items[3].data = CHAR_PAD;
                n = 3'd4;
            end
            else
            begin
                gb_next = egb;
                gc_next = egc[1:0];
            end
        end
        else if (!pad_reg)
        begin
            if (in_data_reg == CHAR_PAD)
            begin
                fen      = 1'b1;
                pad_next = 1'b1;
                gb_next  = '0;
                gc_next  = '0;
            end
            else if (!dv[6])
            begin
                items[0].bad = 1'b1;
                n    = 3'd1;
                base = 2'd1;
                fen  = in_last_reg;
            end
            else if (gc_reg == 2'd3)
            begin
                items[0].data = dgb[23:16] ^ k0;
                items[1].data = dgb[15:8] ^ k1;
                items[2].data = dgb[7:0] ^ k2;
                n        = 3'd3;
                pos_next = p3;
                gb_next  = '0;
                gc_next  = '0;
            end
            else
            begin
                gb_next = dgb;
                gc_next = gc_reg + 2'd1;
                fen     = in_last_reg;
                fgb     = dgb;
                fgc     = {1'b0, gc_reg} + 3'd1;
            end

            if (fen)
            begin
                if (fgc == 3'd2)
                begin
                    items[base].data = fgb[11:4] ^ k0;
                    n        = {1'b0, base} + 3'd1;
                    pos_next = p1;
                end
                else if (fgc == 3'd3)
                begin
                    items[base].data         = fgb[17:10] ^ k0;
                    items[base + 2'd1].data  = fgb[9:2] ^ k1;
                    n        = {1'b0, base} + 3'd2;
                    pos_next = p2;
                end
                gb_next = '0;
                gc_next = '0;
            end
        end

        if (in_last_reg)
        begin
            if (n != '0)
                items[2'(n - 3'd1)].last = 1'b1;
            pos_next = '0;
            gb_next  = '0;
            gc_next  = '0;
            pad_next = 1'b0;
        end
    end

    assign ld.valid = fire;
    assign ld.count = n;
    assign ld.items = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pos_reg    <= '0;
            gb_reg     <= '0;
            gc_reg     <= '0;
            pad_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (clear)
            begin
                pos_reg <= '0;
                gb_reg  <= '0;
                gc_reg  <= '0;
                pad_reg <= 1'b0;
            end
            else if (fire)
            begin
                pos_reg <= pos_next;
                gb_reg  <= gb_next;
                gc_reg  <= gc_next;
                pad_reg <= pad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

endmodule

/* hw/rtl/xkb_obuf.sv */
// result buffer: holds up to four results of one item and sends one per cycle while the receiver is ready
// depends on xkb_pkg; fed by xkb_engine
module xkb_obuf
    import xkb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ld_t        ld,
    output logic       ld_rdy,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,
    output logic [0:0] m_tuser    // bad_char
);

    res_t [RES_MAX-1:0]   items_reg;
    logic [RES_CNT_W-1:0] cnt_reg;
    logic                 pop;

    assign m_tvalid = (cnt_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign ld_rdy   = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && m_tready);

    assign m_tdata    = items_reg[0].data;
    assign m_tlast    = items_reg[0].last;
    assign m_tuser[0] = items_reg[0].bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (ld.valid)
            cnt_reg <= ld.count;
        else if (pop)
            cnt_reg <= cnt_reg - RES_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (ld.valid)
            items_reg <= ld.items;
        else if (pop)
            items_reg <= {res_t'('0), items_reg[RES_MAX-1:1]};
    end

endmodule

/* bench/xkb_bench_pkg.sv */
`timescale 1ns / 100ps
// scoreboard class for the xor key base64 codec bench: its own model of the codec
// and a queue of the output items still due; depends on xkb_pkg for res_t, cfg_reg_e and CHAR_PAD
package xkb_bench_pkg;
    import xkb_pkg::*;

    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    function automatic logic [7:0] alphabet_char(input int idx);
        return B64_ALPHABET[8*(63-idx) +: 8];
    endfunction

    // index of c in the alphabet, or -1
    function automatic int sextet_of(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (alphabet_char(i) == c)
                return i;
        end
        return -1;
    endfunction

    class codec_scoreboard;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic        decode;
        logic [2:0]  key_pos;
        logic [23:0] grp;
        logic [1:0]  grp_cnt;
        logic        pad_seen;
        res_t        out_due[$];
        int          errors;
        int          items_in;
        int          items_out;
        int          flags_seen;
        int          ends_seen;

        function new();
            key        = '0;
            key_len    = 4'd1;
            decode     = 1'b0;
            errors     = 0;
            items_in   = 0;
            items_out  = 0;
            flags_seen = 0;
            ends_seen  = 0;
            clear_state();
        endfunction

        function void clear_state();
            key_pos  = '0;
            grp      = '0;
            grp_cnt  = '0;
            pad_seen = 1'b0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [63:0] v);
            case (idx)
                REG_KEY_BYTES:   key = v;
                REG_KEY_LENGTH:  key_len = v[3:0];
                REG_DECODE_MODE:
                begin
                    decode = v[0];
                    clear_state();
                end
                default: ;
            endcase
        endfunction

        function int pending();
            return out_due.size();
        endfunction

        function logic [7:0] next_key();
            logic [3:0] len;
            logic [7:0] k;
            len = (key_len == 4'd0) ? 4'd1 : ((key_len > 4'd8) ? 4'd8 : key_len);
            if ({1'b0, key_pos} >= len)
                key_pos = '0;
            k = key[8*key_pos +: 8];
            key_pos = (({1'b0, key_pos} + 4'd1) >= len) ? 3'd0 : key_pos + 3'd1;
            return k;
        endfunction

        function void push_out(logic [7:0] d, logic bad);
            res_t r;
            r.data = d;
            r.last = 1'b0;
            r.bad  = bad;
            out_due.push_back(r);
        endfunction

        function void flush_group();
            if (grp_cnt == 2'd2)
                push_out(grp[11:4] ^ next_key(), 1'b0);
            else if (grp_cnt == 2'd3)
            begin
                push_out(grp[17:10] ^ next_key(), 1'b0);
                push_out(grp[9:2] ^ next_key(), 1'b0);
            end
            grp     = '0;
            grp_cnt = '0;
        endfunction

        function void encode_byte(logic [7:0] b, logic l);
            logic [23:0] g;
            grp     = {grp[15:0], b ^ next_key()};
            grp_cnt = grp_cnt + 2'd1;
            if (grp_cnt == 2'd3)
            begin
                push_out(alphabet_char(grp[23:18]), 1'b0);
                push_out(alphabet_char(grp[17:12]), 1'b0);
                push_out(alphabet_char(grp[11:6]), 1'b0);
                push_out(alphabet_char(grp[5:0]), 1'b0);
                grp     = '0;
                grp_cnt = '0;
            end
            else if (l)
            begin
                g = (grp_cnt == 2'd1) ? {grp[7:0], 16'h0} : {grp[15:0], 8'h0};
                push_out(alphabet_char(g[23:18]), 1'b0);
                push_out(alphabet_char(g[17:12]), 1'b0);
                if (grp_cnt == 2'd2)
                    push_out(alphabet_char(g[11:6]), 1'b0);
                else
                    push_out(CHAR_PAD, 1'b0);
                push_out(CHAR_PAD, 1'b0);
            end
        endfunction

        function void decode_char(logic [7:0] c, logic l);
            int v;
            if (pad_seen)
                return;
            v = sextet_of(c);
            if (c == CHAR_PAD)
            begin
                flush_group();
                pad_seen = 1'b1;
            end
            else if (v < 0)
                push_out(8'h00, 1'b1);
            else
            begin
                grp = {grp[17:0], 6'(v)};
                if (grp_cnt == 2'd3)
                begin
                    push_out(grp[23:16] ^ next_key(), 1'b0);
                    push_out(grp[15:8] ^ next_key(), 1'b0);
                    push_out(grp[7:0] ^ next_key(), 1'b0);
                    grp     = '0;
                    grp_cnt = '0;
                end
                else
                    grp_cnt = grp_cnt + 2'd1;
            end
            if (l && !pad_seen)
                flush_group();
        endfunction

        function void note_input(logic [7:0] b, logic l);
            int   due_start;
            res_t r;
            due_start = out_due.size();
            if (decode)
                decode_char(b, l);
            else
                encode_byte(b, l);
            if (l)
            begin
                if (out_due.size() > due_start)
                begin
                    r = out_due.pop_back();
                    r.last = 1'b1;
                    out_due.push_back(r);
                end
                clear_state();
            end
            items_in++;
        endfunction

        function void check_result(logic [7:0] d, logic l, logic bad);
            res_t want;
            items_out++;
            if (bad === 1'b1)
                flags_seen++;
            if (l === 1'b1)
                ends_seen++;
            if (out_due.size() == 0)
            begin
                $display("%0t: unexpected item, got byte %02h last %b bad %b", $time, d, l, bad);
                errors++;
                return;
            end
            want = out_due.pop_front();
            if (d !== want.data)
            begin
                $display("%0t: out_byte expected %02h, got %02h", $time, want.data, d);
                errors++;
            end
            if (l !== want.last)
            begin
                $display("%0t: out_last expected %b, got %b", $time, want.last, l);
                errors++;
            end
            if (bad !== want.bad)
            begin
                $display("%0t: bad_char expected %b, got %b", $time, want.bad, bad);
                errors++;
            end
        endfunction
    endclass

endpackage

/* bench/tb_xor_key_base64_codec_top.sv */
`timescale 1ns / 100ps
// bench top for xor_key_base64_codec_top: directed encode and decode messages, then
// random messages over several key settings and idle patterns; depends on xkb_pkg, xkb_bench_pkg
module tb_xor_key_base64_codec_top;
    import xkb_pkg::*;
    import xkb_bench_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int PHASE_ITEMS     = 12;
    localparam int RANDOM_PHASES   = 6;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;   // data_byte
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [7:0]             m_tdata;        // out_byte
    logic                   m_tlast;
    logic [0:0]             m_tuser;        // bad_char
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int              src_idle_pct = 0;
    int              snk_stall_pct = 0;
    int              hold_left = 0;
    int              quiet_cycles = 0;
    codec_scoreboard sb;

    xor_key_base64_codec_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast, m_tuser[0]);
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 58; snk_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 58; end
            default:       begin src_idle_pct = 31; snk_stall_pct = 31; end
        endcase
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_item(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(b, l);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], last_at_end && (i == s.len() - 1));
    endtask

    // wait for every due item, then let the block run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic send_plain_msg(output int n);
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), (i == len - 1) && ($urandom_range(9) != 0));
        n = len;
    endtask

    // mostly well-formed base64 text, some unpadded, some with noise bytes
    task automatic send_b64_msg(output int n);
        int         nchar;
        int         npad;
        int         style;
        bit         tail;
        logic [7:0] c;
        nchar = $urandom_range(1, 12);
        style = $urandom_range(99);
        npad  = (style < 65 && nchar % 4 != 0) ? 4 - nchar % 4 : 0;
        tail  = (style < 65) && ($urandom_range(3) == 0);
        for (int i = 0; i < nchar; i++)
        begin
            c = alphabet_char($urandom_range(63));
            if (style >= 85 && $urandom_range(3) == 0)
                c = 8'($urandom_range(255));
            send_item(c, (i == nchar - 1) && npad == 0 && !tail
                         && (style < 85 || $urandom_range(4) != 0));
        end
        for (int i = 0; i < npad; i++)
            send_item(CHAR_PAD, (i == npad - 1) && !tail);
        if (tail)
            send_item(alphabet_char($urandom_range(63)), 1'b1);
        n = nchar + npad;
    endtask

    initial
    begin
        int          cnt;
        int          n;
        logic [3:0]  klen;
        logic [63:0] kbytes;
        sb = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // encode: full group, one- and two-byte flushes
        set_idling(IDLE_NONE);
        write_reg(REG_KEY_BYTES, 64'h0123_4567_89AB_CDEF);
        write_reg(REG_KEY_LENGTH, 64'd3);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b1);
        send_item(8'h01, 1'b0);
        send_item(8'h02, 1'b1);
        // key position left beyond a shorter key length
        settle();
        write_reg(REG_KEY_LENGTH, 64'd8);
        send_item(8'hAA, 1'b0);
        send_item(8'hBB, 1'b0);
        settle();
        write_reg(REG_KEY_LENGTH, 64'd1);
        send_item(8'hCC, 1'b1);

        // decode: alphabet edges, bad chars, padding, ignored tail, short ends
        settle();
        set_idling(IDLE_RECEIVER);
        write_reg(REG_DECODE_MODE, 64'd1);
        write_reg(REG_KEY_LENGTH, 64'd0);
        write_reg(REG_KEY_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        send_text("Az+/", 1'b0);
        send_text("Za09", 1'b0);
        send_item("!", 1'b0);
        send_text("QQ", 1'b0);
        send_item(CHAR_PAD, 1'b0);
        send_item("x", 1'b0);
        send_item("Q", 1'b1);
        send_item("A", 1'b1);
        send_text("ABC", 1'b1);
        send_item("*", 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p)
                0:       klen = 4'd8;
                1:       klen = 4'd15;
                2:       klen = 4'd0;
                3:       klen = 4'd1;
                default: klen = 4'($urandom_range(15));
            endcase
            kbytes = (p == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
            write_reg(REG_DECODE_MODE, 64'(p % 2));
            write_reg(REG_KEY_LENGTH, 64'(klen));
            write_reg(REG_KEY_BYTES, kbytes);
            set_idling(idle_mode_e'(p % 4));
            if (p == 4)
                hold_left = HOLD_OFF_CYCLES;
            cnt = 0;
            while (cnt < PHASE_ITEMS)
            begin
                if (p % 2 != 0)
                    send_b64_msg(n);
                else
                    send_plain_msg(n);
                cnt += n;
            end
        end
        settle();

        $display("run covered %0d input items and %0d output items in both modes",
                 sb.items_in, sb.items_out);
        $display("key lengths 0 to 15, %0d flagged chars, %0d message ends, %0d-cycle hold-off",
                 sb.flags_seen, sb.ends_seen, HOLD_OFF_CYCLES);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
